/* hw/rtl/tbe_pkg.sv */
package tbe_pkg;

    // Item codes carried in the mode field
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    localparam int TICK_W = 32;

    typedef struct packed {
        logic [1:0]        mode;
        logic [3:0]        slot_index;
        logic              one_shot;
        logic [TICK_W-1:0] period_ticks;
    } in_beat_t;

    typedef struct packed {
        logic [3:0]        expired_slot;
        logic              stays_active;
        logic [TICK_W-1:0] tick_now;
        logic              last_event;
    } out_beat_t;

endpackage

/* hw/rtl/timer_bank_expiry.sv */
// timer_bank_expiry: bank of one-shot / periodic timer slots on a 32-bit tick.
//
// Channels: in (in_valid/in_ready/in_data) takes tick, start and stop beats;
// out (out_valid/out_ready/out_data) gives one beat per expiry, in slot order,
// last_event set on the final beat of a tick. cfg_we/cfg_wdata write
// service_enable; ticks are dropped while it is 0.
//
// Sequence: start, stop, dropped ticks and unused codes finish in the idle
// state. A live tick is accepted, then the tick is incremented, then a walk
// over all slots runs through one shared 32-bit adder: each slot is read, an
// active slot is compared, and a periodic slot that rearms is advanced. A
// second walk then emits the expiries in slot order up to the last hit (it
// returns to idle when nothing expired); an out_ready stall holds it.
// in_ready is high only between items.
//
// Reset clears the tick, all active bits, the enable and the output valid.
// Slot start/period storage has no reset; it is only read for active slots,
// which a start has written. A stalled receiver holds the walk in its emit
// phase; the output register keeps the beat until taken.
module timer_bank_expiry #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tbe_pkg::in_beat_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tbe_pkg::out_beat_t out_data,
    input  logic              cfg_we,
    input  logic              cfg_wdata
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INC  = 6'b000010,
        S_RD   = 6'b000100,
        S_CMP  = 6'b001000,
        S_ADV  = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [tbe_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic [IDX_W-1:0]           walk_idx_reg, walk_idx_next;
    logic [TIMER_SLOTS-1:0]     active_reg, active_next;
    logic [TIMER_SLOTS-1:0]     one_shot_reg, one_shot_next;
    logic [TIMER_SLOTS-1:0]     hit_reg, hit_next;
    logic                       enable_reg, enable_next;
    logic                       out_valid_reg, out_valid_next;
    tbe_pkg::out_beat_t         out_data_reg, out_data_next;

    // slot storage: one write port, one registered read port at walk_idx
    logic [tbe_pkg::TICK_W-1:0] start_mem_reg [TIMER_SLOTS];
    logic [tbe_pkg::TICK_W-1:0] period_mem_reg [TIMER_SLOTS];
    logic [tbe_pkg::TICK_W-1:0] rd_start_reg;
    logic [tbe_pkg::TICK_W-1:0] rd_period_reg;

    logic                       start_we;
    logic                       period_we;
    logic [IDX_W-1:0]           mem_waddr;
    logic [tbe_pkg::TICK_W-1:0] mem_wstart;
    logic [tbe_pkg::TICK_W-1:0] mem_wperiod;

    // shared adder: tick increment, elapsed time, start advance
    logic [tbe_pkg::TICK_W-1:0] add_a;
    logic [tbe_pkg::TICK_W-1:0] add_b;
    logic                       add_cin;
    logic [tbe_pkg::TICK_W-1:0] add_sum;

    logic                       in_range;
    logic [IDX_W-1:0]           in_addr;
    logic                       last_slot;
    state_t                     step_state;
    logic [IDX_W-1:0]           step_idx;
    logic [TIMER_SLOTS-1:0]     hit_left;
    logic                       out_free;
    logic                       load_out;
    logic                       emit_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign in_range = 32'(in_data.slot_index) < 32'(TIMER_SLOTS);
    assign in_addr  = IDX_W'(in_data.slot_index);

    assign last_slot  = (walk_idx_reg == LAST_IDX);
    assign step_state = last_slot ? S_EMIT : S_RD;
    assign step_idx   = last_slot ? '0 : walk_idx_reg + IDX_W'(1);

    assign hit_left = hit_reg & ~(TIMER_SLOTS'(1) << walk_idx_reg);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        unique case (state_reg)
            S_INC:
            begin
                add_a   = tick_reg;
                add_b   = '0;
                add_cin = 1'b1;
            end
            S_ADV:
            begin
                add_a   = rd_start_reg;
                add_b   = rd_period_reg;
                add_cin = 1'b0;
            end
            default:
            begin
                // elapsed = tick - start
                add_a   = tick_reg;
                add_b   = ~rd_start_reg;
                add_cin = 1'b1;
            end
        endcase
    end

    assign add_sum = add_a + add_b + tbe_pkg::TICK_W'(add_cin);

    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        walk_idx_next  = walk_idx_reg;
        active_next    = active_reg;
        one_shot_next  = one_shot_reg;
        hit_next       = hit_reg;
        enable_next    = enable_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        start_we       = 1'b0;
        period_we      = 1'b0;
        mem_waddr      = walk_idx_reg;
        mem_wstart     = add_sum;
        mem_wperiod    = rd_period_reg;
        load_out       = 1'b0;
        emit_last      = (hit_left == '0);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg_we)
        begin
            enable_next = cfg_wdata;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_data.mode)
                        tbe_pkg::MODE_START:
                        begin
                            if (in_range)
                            begin
                                start_we   = 1'b1;
                                period_we  = 1'b1;
                                mem_waddr  = in_addr;
                                mem_wstart = tick_reg;
                                mem_wperiod = (in_data.period_ticks == '0)
                                            ? tbe_pkg::TICK_W'(1) : in_data.period_ticks;
                                active_next[in_addr]   = 1'b1;
                                one_shot_next[in_addr] = in_data.one_shot;
                            end
                        end
                        tbe_pkg::MODE_STOP:
                        begin
                            if (in_range)
                            begin
                                active_next[in_addr] = 1'b0;
                            end
                        end
                        tbe_pkg::MODE_TICK:
                        begin
                            if (enable_reg)
                            begin
                                state_next = S_INC;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_INC:
            begin
                tick_next     = add_sum;
                walk_idx_next = '0;
                hit_next      = '0;
                state_next    = S_RD;
            end
            S_RD:
            begin
                if (active_reg[walk_idx_reg])
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    state_next    = step_state;
                    walk_idx_next = step_idx;
                end
            end
            S_CMP:
            begin
                if (add_sum >= rd_period_reg)
                begin
                    hit_next[walk_idx_reg] = 1'b1;
                    if (one_shot_reg[walk_idx_reg])
                    begin
                        active_next[walk_idx_reg] = 1'b0;
                        state_next    = step_state;
                        walk_idx_next = step_idx;
                    end
                    else
                    begin
                        state_next = S_ADV;
                    end
                end
                else
                begin
                    state_next    = step_state;
                    walk_idx_next = step_idx;
                end
            end
            S_ADV:
            begin
                start_we      = 1'b1;
                state_next    = step_state;
                walk_idx_next = step_idx;
            end
            S_EMIT:
            begin
                if (hit_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (hit_reg[walk_idx_reg])
                begin
                    if (out_free)
                    begin
                        load_out       = 1'b1;
                        out_valid_next = 1'b1;
                        out_data_next.expired_slot = 4'(walk_idx_reg);
                        out_data_next.stays_active = !one_shot_reg[walk_idx_reg];
                        out_data_next.tick_now     = tick_reg;
                        out_data_next.last_event   = emit_last;
                        hit_next[walk_idx_reg]     = 1'b0;
                        if (emit_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            walk_idx_next = walk_idx_reg + IDX_W'(1);
                        end
                    end
                end
                else
                begin
                    walk_idx_next = walk_idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= '0;
            walk_idx_reg  <= '0;
            active_reg    <= '0;
            one_shot_reg  <= '0;
            hit_reg       <= '0;
            enable_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            walk_idx_reg  <= walk_idx_next;
            active_reg    <= active_next;
            one_shot_reg  <= one_shot_next;
            hit_reg       <= hit_next;
            enable_reg    <= enable_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (start_we)
        begin
            start_mem_reg[mem_waddr] <= mem_wstart;
        end
        if (period_we)
        begin
            period_mem_reg[mem_waddr] <= mem_wperiod;
        end
        rd_start_reg  <= start_mem_reg[walk_idx_reg];
        rd_period_reg <= period_mem_reg[walk_idx_reg];
    end

    // a live tick moves the counter by exactly one
    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.mode == tbe_pkg::MODE_TICK && enable_reg)
        |-> ##2 (tick_reg == $past(tick_reg, 2) + tbe_pkg::TICK_W'(1)))
        else $error("tick did not advance by one");

    // the beat flagged last leaves no expiry behind
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && emit_last) |=> (hit_reg == '0))
        else $error("expiries left after last beat");

    // no pending expiry while taking new items
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (hit_reg == '0))
        else $error("pending expiries while idle");

endmodule

/* tb/timer_bank_expiry_tb.sv */
module timer_bank_expiry_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // mode 3 has no meaning in the block; it must be swallowed silently
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int NUM_SLOTS = 16;
    // the worst walk compares and advances every slot; leave plenty of margin before touching cfg
    localparam int SETTLE_CYCLES = 100;
    localparam int LONG_HOLD_CYCLES = 400;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    tbe_pkg::in_beat_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    tbe_pkg::out_beat_t out_data;
    logic               cfg_we = 1'b0;
    logic               cfg_wdata = 1'b0;

    timer_bank_expiry #(
        .TIMER_SLOTS(NUM_SLOTS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the timer bank. Updated at the edge where an input
    // beat is accepted; every expiry it predicts goes to due_expiries.
    // ------------------------------------------------------------------
    logic        svc_en = 1'b0;
    logic [31:0] tick_cnt = '0;
    logic        armed     [NUM_SLOTS];
    logic        fire_once [NUM_SLOTS];
    logic [31:0] slot_base [NUM_SLOTS];
    logic [31:0] slot_len  [NUM_SLOTS];

    tbe_pkg::in_beat_t  timer_cmds[$];     // beats waiting for the driver
    tbe_pkg::out_beat_t due_expiries[$];   // expiries predicted, not yet seen

    int mismatches = 0;
    int beats_sent = 0;
    int live_ticks = 0;
    int expiries_seen = 0;
    int enable_writes = 0;
    int hold_asked = 0;
    int hold_done = 0;

    function automatic void predict_timer_cmd(tbe_pkg::in_beat_t cmd);
        tbe_pkg::out_beat_t hits[$];
        tbe_pkg::out_beat_t ev;
        logic [31:0]        elapsed;
        case (cmd.mode)
            tbe_pkg::MODE_START:
            begin
                armed[cmd.slot_index]     = 1'b1;
                fire_once[cmd.slot_index] = cmd.one_shot;
                slot_len[cmd.slot_index]  = (cmd.period_ticks == '0) ? 32'd1
                                                                     : cmd.period_ticks;
                slot_base[cmd.slot_index] = tick_cnt;
            end
            tbe_pkg::MODE_STOP:
            begin
                armed[cmd.slot_index] = 1'b0;
            end
            tbe_pkg::MODE_TICK:
            begin
                // dropped entirely while service is off
                if (svc_en)
                begin
                    tick_cnt = tick_cnt + 32'd1;
                    live_ticks++;
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        elapsed = tick_cnt - slot_base[i];   // modulo 2^32
                        if (armed[i] && elapsed >= slot_len[i])
                        begin
                            // at most one expiry per slot per tick, even if behind
                            if (fire_once[i])
                                armed[i] = 1'b0;
                            else
                                slot_base[i] = slot_base[i] + slot_len[i];
                            ev.expired_slot = i[3:0];
                            ev.stays_active = ~fire_once[i];
                            ev.tick_now     = tick_cnt;
                            ev.last_event   = 1'b0;
                            hits.push_back(ev);
                        end
                    end
                    foreach (hits[k])
                    begin
                        ev = hits[k];
                        ev.last_event = (k == hits.size() - 1);
                        due_expiries.push_back(ev);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of back-to-back beats separated by random gaps.
    // A beat stays on the bus unchanged until in_ready takes it.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left = 4;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_timer_cmd(in_data);
                void'(timer_cmds.pop_front());
                beats_sent++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    // about a quarter of the bursts run straight into the next
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (timer_cmds.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= timer_cmds[0];
                end
                else
                    in_valid <= 1'b0;
            end
            else if (!in_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (timer_cmds.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= timer_cmds[0];
                end
            end
            // valid but not taken: hold the beat as is
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every expiry beat against the oldest prediction.
    // out_ready follows a randomly redrawn pattern (always ready, 3-of-4
    // ready, coin flip), and on request drops for a long stretch so the
    // block backs up into its input.
    // ------------------------------------------------------------------
    int rx_cycle = 0;
    int rx_style = 0;
    int hold_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        tbe_pkg::out_beat_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_cycle  = 0;
            rx_style  = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                expiries_seen++;
                if (due_expiries.size() == 0)
                begin
                    $error("expiry beat with none predicted: slot %0d tick %0d",
                           out_data.expired_slot, out_data.tick_now);
                    mismatches++;
                end
                else
                begin
                    want = due_expiries.pop_front();
                    if (out_data.expired_slot !== want.expired_slot)
                    begin
                        $error("expired_slot: expected %0d, got %0d",
                               want.expired_slot, out_data.expired_slot);
                        mismatches++;
                    end
                    if (out_data.stays_active !== want.stays_active)
                    begin
                        $error("stays_active: expected %0d, got %0d",
                               want.stays_active, out_data.stays_active);
                        mismatches++;
                    end
                    if (out_data.tick_now !== want.tick_now)
                    begin
                        $error("tick_now: expected %0d, got %0d",
                               want.tick_now, out_data.tick_now);
                        mismatches++;
                    end
                    if (out_data.last_event !== want.last_event)
                    begin
                        $error("last_event: expected %0d, got %0d",
                               want.last_event, out_data.last_event);
                        mismatches++;
                    end
                end
            end

            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_style = $urandom_range(0, 2);
            if (hold_asked != hold_done)
            begin
                hold_done = hold_asked;
                hold_left = LONG_HOLD_CYCLES;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_style == 0)
                out_ready <= 1'b1;
            else if (rx_style == 1)
                out_ready <= (rx_cycle % 4 != 3);
            else
                out_ready <= 1'($urandom_range(0, 1));
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_cmd(logic [1:0] m, logic [3:0] s, logic sh, logic [31:0] p);
        tbe_pkg::in_beat_t cmd;
        cmd.mode         = m;
        cmd.slot_index   = s;
        cmd.one_shot     = sh;
        cmd.period_ticks = p;
        timer_cmds.push_back(cmd);
    endtask

    // everything sent has been taken, every predicted expiry has come back,
    // and the slot walk has had time to finish
    task automatic wait_idle();
        do
            @(posedge clk);
        while (timer_cmds.size() != 0 || in_valid || due_expiries.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_service_enable(logic v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        svc_en    = v;
        enable_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly ticks and short-period starts so slots keep expiring; now and
    // then every slot is armed with period 0..2 so a tick can yield up to 16 beats.
    // Ticks while disabled and unused codes don't count toward the target.
    task automatic queue_random(int target);
        int          live;
        int          pick;
        logic [31:0] per;
        live = 0;
        while (live < target)
        begin
            pick = $urandom_range(0, 99);
            per  = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 6);
            if (pick < 2)
            begin
                for (int k = 0; k < NUM_SLOTS; k++)
                    push_cmd(tbe_pkg::MODE_START, 4'(k), 1'($urandom_range(0, 1)),
                             $urandom_range(0, 2));
                live += NUM_SLOTS;
            end
            else if (pick < 50)
            begin
                push_cmd(tbe_pkg::MODE_TICK, 4'($urandom()), 1'($urandom()), $urandom());
                if (svc_en)
                    live++;
            end
            else if (pick < 78)
            begin
                push_cmd(tbe_pkg::MODE_START, 4'($urandom()), 1'($urandom()), per);
                live++;
            end
            else if (pick < 94)
            begin
                push_cmd(tbe_pkg::MODE_STOP, 4'($urandom()), 1'($urandom()), $urandom());
                live++;
            end
            else
                push_cmd(MODE_UNUSED, 4'($urandom()), 1'($urandom()), $urandom());
        end
    endtask

    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            armed[i]     = 1'b0;
            fire_once[i] = 1'b0;
            slot_base[i] = '0;
            slot_len[i]  = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Service off: ticks are dropped, starts latch the frozen tick (0)
        write_service_enable(1'b0);
        push_cmd(tbe_pkg::MODE_TICK,  4'd0,  1'b0, 32'd0);
        push_cmd(tbe_pkg::MODE_START, 4'd0,  1'b0, 32'd0);          // period 0 -> 1
        push_cmd(tbe_pkg::MODE_START, 4'd15, 1'b1, 32'd3);
        push_cmd(MODE_UNUSED,         4'd15, 1'b1, 32'hFFFF_FFFF);  // all bits high
        push_cmd(tbe_pkg::MODE_STOP,  4'd5,  1'b0, 32'd0);          // slot never armed
        push_cmd(tbe_pkg::MODE_TICK,  4'd9,  1'b1, 32'hFFFF_FFFF);

        // Service on: periodic slot 0 every tick, one-shot 15 at tick 3
        write_service_enable(1'b1);
        push_cmd(tbe_pkg::MODE_TICK,  4'd0,  1'b0, 32'd0);
        push_cmd(tbe_pkg::MODE_TICK,  4'd0,  1'b0, 32'd0);
        push_cmd(tbe_pkg::MODE_TICK,  4'd0,  1'b0, 32'd0);
        push_cmd(tbe_pkg::MODE_START, 4'd7,  1'b0, 32'hFFFF_FFFF);  // longest period
        push_cmd(tbe_pkg::MODE_START, 4'd3,  1'b1, 32'd2);
        push_cmd(tbe_pkg::MODE_START, 4'd3,  1'b0, 32'd1);          // restart while armed
        push_cmd(tbe_pkg::MODE_START, 4'd8,  1'b1, 32'd1);
        push_cmd(tbe_pkg::MODE_STOP,  4'd0,  1'b0, 32'd0);
        push_cmd(tbe_pkg::MODE_TICK,  4'd15, 1'b1, 32'hFFFF_FFFF);
        push_cmd(tbe_pkg::MODE_STOP,  4'd15, 1'b1, 32'hFFFF_FFFF);  // already expired
        push_cmd(tbe_pkg::MODE_START, 4'd0,  1'b1, 32'd0);
        push_cmd(tbe_pkg::MODE_STOP,  4'd7,  1'b0, 32'd0);
        push_cmd(tbe_pkg::MODE_TICK,  4'd0,  1'b0, 32'd0);
        push_cmd(tbe_pkg::MODE_TICK,  4'd0,  1'b0, 32'd0);

        // Random, service on; the receiver goes deaf for a while right away
        // with ~80 beats queued behind it
        queue_random(40);
        hold_asked++;
        queue_random(40);

        // Sender stops until every expiry is back, then service goes off
        write_service_enable(1'b0);
        queue_random(20);

        write_service_enable(1'b1);
        queue_random(70);

        wait_idle();
        $display("Ran %0d input beats (%0d live ticks, %0d enable writes);",
                 beats_sent, live_ticks, enable_writes);
        $display("checked %0d expiry beats.", expiries_seen);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #4ms;
        $display("timeout: %0d beats still queued, %0d expiries outstanding",
                 timer_cmds.size(), due_expiries.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
